[design/midi_stream_message_splitter_unit_assert.svh]
// Assertion macros shared by the MIDI message splitter RTL.
`ifndef MIDI_STREAM_MESSAGE_SPLITTER_UNIT_ASSERT_SVH
`define MIDI_STREAM_MESSAGE_SPLITTER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MSSU_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("midi splitter check failed");
`define MSSU_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("midi splitter check failed");
`else
`define MSSU_ASSERT(label, clk, rst_n, expr)
`define MSSU_ASSERT_IMP(label, clk, rst_n, pre, post)
`endif
`endif

[design/mssu_pkg.sv]
// Types, constants and decode functions for the MIDI message splitter.
package mssu_pkg;

    localparam logic [7:0] RT_FIRST    = 8'hF8;
    localparam logic [7:0] SX_START    = 8'hF0;
    localparam logic [7:0] SX_END      = 8'hF7;
    localparam logic [7:0] ST_PROG     = 8'hC0;
    localparam logic [7:0] ST_CHPRESS  = 8'hD0;
    localparam logic [7:0] STATUS_MASK = 8'h80;
    localparam logic [7:0] SYS_MTC     = 8'hF1;
    localparam logic [7:0] SYS_SONGPOS = 8'hF2;
    localparam logic [7:0] SYS_SONGSEL = 8'hF3;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_SYSEX = 1'b1;

    typedef enum logic [1:0] {
        CLS_CHANNEL = 2'd0,
        CLS_SYSTEM  = 2'd1
    } pend_class_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] len;
        logic       sx_end;
        logic       run_end;
    } result_t;

    // Outcome of a byte seen with no message waiting for data.
    typedef struct packed {
        logic        has_res;
        result_t     res;
        logic [7:0]  rs;
        logic        sx;
        logic        pstart;
        pend_class_t pclass;
        logic [7:0]  pstatus;
        logic [1:0]  pneed;
        logic [1:0]  pcount;
        logic [7:0]  pfirst;
    } fresh_t;

    function automatic logic [1:0] need_of(input logic [7:0] s);
        logic [1:0] n;
        n = 2'd0;
        if (s < SX_START) begin
            if (s[7:4] == ST_PROG[7:4] || s[7:4] == ST_CHPRESS[7:4]) begin
                n = 2'd1;
            end else begin
                n = 2'd2;
            end
        end else if (s == SYS_MTC || s == SYS_SONGSEL) begin
            n = 2'd1;
        end else if (s == SYS_SONGPOS) begin
            n = 2'd2;
        end
        return n;
    endfunction

    function automatic result_t mk_result(input logic kind, input logic [7:0] b0,
                                          input logic [7:0] b1, input logic [7:0] b2,
                                          input logic [1:0] len, input logic sx_end);
        result_t r;
        r.kind    = kind;
        r.byte0   = b0;
        r.byte1   = b1;
        r.byte2   = b2;
        r.len     = len;
        r.sx_end  = sx_end;
        r.run_end = 1'b0;
        return r;
    endfunction

    function automatic fresh_t fresh_step(input logic [7:0] b, input logic last,
                                          input logic [7:0] rs, input logic sx);
        fresh_t     f;
        logic [1:0] nd;
        f    = '0;
        f.rs = rs;
        f.sx = sx;
        nd   = need_of(b);
        if (b >= RT_FIRST) begin
            f.has_res = 1'b1;
            f.res     = mk_result(KIND_SHORT, b, 8'd0, 8'd0, 2'd1, 1'b0);
        end else if (sx) begin
            f.sx      = (b != SX_END);
            f.has_res = 1'b1;
            f.res     = mk_result(KIND_SYSEX, b, 8'd0, 8'd0, 2'd1, b == SX_END);
        end else if (b == SX_START) begin
            f.sx      = 1'b1;
            f.rs      = 8'd0;
            f.has_res = 1'b1;
            f.res     = mk_result(KIND_SYSEX, b, 8'd0, 8'd0, 2'd1, 1'b0);
        end else if ((b & STATUS_MASK) != 8'd0) begin
            if (b >= SX_START) begin
                f.rs = 8'd0;
                if (nd != 2'd0 && !last) begin
                    f.pstart  = 1'b1;
                    f.pclass  = CLS_SYSTEM;
                    f.pstatus = b;
                    f.pneed   = nd;
                end else begin
                    f.has_res = 1'b1;
                    f.res     = mk_result(KIND_SHORT, b, 8'd0, 8'd0, 2'd1, 1'b0);
                end
            end else if (!last) begin
                f.pstart  = 1'b1;
                f.pclass  = CLS_CHANNEL;
                f.pstatus = b;
                f.pneed   = nd;
            end
        end else if (rs != 8'd0) begin
            if (need_of(rs) == 2'd1) begin
                f.has_res = 1'b1;
                f.res     = mk_result(KIND_SHORT, rs, b, 8'd0, 2'd2, 1'b0);
            end else if (!last) begin
                f.pstart  = 1'b1;
                f.pclass  = CLS_CHANNEL;
                f.pstatus = rs;
                f.pneed   = 2'd2;
                f.pcount  = 2'd1;
                f.pfirst  = b;
            end
        end
        return f;
    endfunction

endpackage

[design/midi_stream_message_splitter_unit.sv]
// MIDI byte stream splitter: running status, real-time pass-through, streamed SysEx.
//
//  channel | ports                                   | direction | per request
//  --------+-----------------------------------------+-----------+---------------------------
//  s_      | s_valid s_ready s_midi_byte             | in        | one raw byte + buffer end
//          | s_buffer_last                           |           |
//  m_      | m_valid m_ready m_msg_kind m_byte0..2   | out       | one message or SysEx byte
//          | m_msg_length m_sysex_end m_run_end      |           |
//
// A byte is taken into an input register, decoded combinationally and its results written
// into a two-entry result queue; the first result is presented from the queue once the
// byte has passed the input register and been written there. One byte per cycle is sustained
// while the result queue has room; a byte that yields two results presents them in turn on
// the single output port. Reset (aresetn low, synchronous) empties both registers and clears
// running status, SysEx and pending-message state. Either side may stall.
`include "midi_stream_message_splitter_unit_assert.svh"

module midi_stream_message_splitter_unit
    import mssu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_midi_byte,
    input  logic       s_buffer_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_msg_kind,
    output logic [7:0] m_byte0,
    output logic [7:0] m_byte1,
    output logic [7:0] m_byte2,
    output logic [1:0] m_msg_length,
    output logic       m_sysex_end,
    output logic       m_run_end
);

    logic        ir_valid_reg;
    logic [7:0]  ir_byte_reg;
    logic        ir_last_reg;

    logic [7:0]  rs_reg, rs_next;
    logic        sx_reg, sx_next;
    logic        pact_reg, pact_next;
    pend_class_t pclass_reg, pclass_next;
    logic [7:0]  pstatus_reg, pstatus_next;
    logic [1:0]  pneed_reg, pneed_next;
    logic [1:0]  pcount_reg, pcount_next;
    logic [7:0]  pfirst_reg, pfirst_next;

    result_t     fifo_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;

    result_t     r0, r1;
    logic [1:0]  n_res;
    logic [1:0]  free_slots;
    logic        pop;
    logic        proc;
    fresh_t      f;

    assign pop        = m_valid && m_ready;
    assign free_slots = 2'd2 - cnt_reg + {1'b0, pop};
    assign proc       = ir_valid_reg && (n_res <= free_slots);
    assign s_ready    = !ir_valid_reg || proc;

    always_comb begin
        rs_next      = rs_reg;
        sx_next      = sx_reg;
        pact_next    = pact_reg;
        pclass_next  = pclass_reg;
        pstatus_next = pstatus_reg;
        pneed_next   = pneed_reg;
        pcount_next  = pcount_reg;
        pfirst_next  = pfirst_reg;
        r0           = '0;
        r1           = '0;
        n_res        = 2'd0;
        f            = fresh_step(ir_byte_reg, ir_last_reg, rs_reg, sx_reg);

        if (pact_reg) begin
            if (pneed_reg == 2'd2 && pcount_reg == 2'd0) begin
                if (ir_last_reg) begin
                    pact_next    = 1'b0;
                    pclass_next  = CLS_CHANNEL;
                    pstatus_next = 8'd0;
                    pneed_next   = 2'd0;
                    pcount_next  = 2'd0;
                    pfirst_next  = 8'd0;
                    // A system-common status cut off by the buffer end goes out alone and
                    // the byte that ended the buffer is decoded again as a fresh byte.
                    if (pclass_reg == CLS_SYSTEM) begin
                        r0      = mk_result(KIND_SHORT, pstatus_reg, 8'd0, 8'd0, 2'd1, 1'b0);
                        r1      = f.res;
                        n_res   = f.has_res ? 2'd2 : 2'd1;
                        rs_next = f.rs;
                        sx_next = f.sx;
                    end
                end else begin
                    pfirst_next = ir_byte_reg;
                    pcount_next = 2'd1;
                end
            end else begin
                if (pneed_reg == 2'd1) begin
                    r0 = mk_result(KIND_SHORT, pstatus_reg, ir_byte_reg, 8'd0, 2'd2, 1'b0);
                end else begin
                    r0 = mk_result(KIND_SHORT, pstatus_reg, pfirst_reg, ir_byte_reg,
                                   2'd3, 1'b0);
                end
                n_res = 2'd1;
                if (pclass_reg == CLS_CHANNEL) begin
                    rs_next = pstatus_reg;
                end
                pact_next    = 1'b0;
                pclass_next  = CLS_CHANNEL;
                pstatus_next = 8'd0;
                pneed_next   = 2'd0;
                pcount_next  = 2'd0;
                pfirst_next  = 8'd0;
            end
        end else begin
            r0      = f.res;
            n_res   = {1'b0, f.has_res};
            rs_next = f.rs;
            sx_next = f.sx;
            if (f.pstart) begin
                pact_next    = 1'b1;
                pclass_next  = f.pclass;
                pstatus_next = f.pstatus;
                pneed_next   = f.pneed;
                pcount_next  = f.pcount;
                pfirst_next  = f.pfirst;
            end
        end

        if (n_res == 2'd2) begin
            r1.run_end = 1'b1;
        end else begin
            r0.run_end = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ir_valid_reg <= 1'b0;
            rs_reg       <= 8'd0;
            sx_reg       <= 1'b0;
            pact_reg     <= 1'b0;
            pclass_reg   <= CLS_CHANNEL;
            pstatus_reg  <= 8'd0;
            pneed_reg    <= 2'd0;
            pcount_reg   <= 2'd0;
            pfirst_reg   <= 8'd0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            cnt_reg      <= 2'd0;
        end else begin
            if (s_valid && s_ready) begin
                ir_valid_reg <= 1'b1;
            end else if (proc) begin
                ir_valid_reg <= 1'b0;
            end
            if (proc) begin
                rs_reg      <= rs_next;
                sx_reg      <= sx_next;
                pact_reg    <= pact_next;
                pclass_reg  <= pclass_next;
                pstatus_reg <= pstatus_next;
                pneed_reg   <= pneed_next;
                pcount_reg  <= pcount_next;
                pfirst_reg  <= pfirst_next;
                wr_ptr_reg  <= wr_ptr_reg ^ n_res[0];
                cnt_reg     <= cnt_reg + n_res - {1'b0, pop};
            end else begin
                cnt_reg <= cnt_reg - {1'b0, pop};
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ir_byte_reg <= s_midi_byte;
            ir_last_reg <= s_buffer_last;
        end
        if (proc && n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= r0;
        end
        if (proc && n_res == 2'd2) begin
            fifo_reg[!wr_ptr_reg] <= r1;
        end
    end

    assign m_valid      = (cnt_reg != 2'd0);
    assign m_msg_kind   = fifo_reg[rd_ptr_reg].kind;
    assign m_byte0      = fifo_reg[rd_ptr_reg].byte0;
    assign m_byte1      = fifo_reg[rd_ptr_reg].byte1;
    assign m_byte2      = fifo_reg[rd_ptr_reg].byte2;
    assign m_msg_length = fifo_reg[rd_ptr_reg].len;
    assign m_sysex_end  = fifo_reg[rd_ptr_reg].sx_end;
    assign m_run_end    = fifo_reg[rd_ptr_reg].run_end;

    `MSSU_ASSERT(a_queue_bound, aclk, aresetn, cnt_reg != 2'd3)
    `MSSU_ASSERT(a_no_pend_in_sysex, aclk, aresetn, !(pact_reg && sx_reg))
    `MSSU_ASSERT_IMP(a_syscommon_no_rs, aclk, aresetn,
                     pact_reg && pclass_reg == CLS_SYSTEM, rs_reg == 8'd0)
    `MSSU_ASSERT_IMP(a_sysex_shape, aclk, aresetn, m_valid && m_msg_kind == KIND_SYSEX,
                     m_msg_length == 2'd1 && m_byte1 == 8'd0 && m_byte2 == 8'd0)

endmodule

[test/tb_top.sv]
// Self-checking testbench for the MIDI stream message splitter.
`timescale 1ns / 100ps

module tb_top
    import mssu_pkg::*;
();

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic       kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] len;
        logic       sx_end;
        logic       run_end;
    } midi_msg_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_midi_byte = 8'd0;
    logic       s_buffer_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_msg_kind;
    logic [7:0] m_byte0;
    logic [7:0] m_byte1;
    logic [7:0] m_byte2;
    logic [1:0] m_msg_length;
    logic       m_sysex_end;
    logic       m_run_end;

    // Parser state as predicted from the accepted bytes.
    logic [7:0]  run_status = 8'd0;
    logic        sysex_on = 1'b0;
    logic        wait_on = 1'b0;
    pend_class_t wait_cls = CLS_CHANNEL;
    logic [7:0]  wait_status = 8'd0;
    logic [1:0]  wait_need = 2'd0;
    logic [1:0]  wait_count = 2'd0;
    logic [7:0]  wait_first = 8'd0;

    midi_msg_t msgs_due[$];
    midi_msg_t byte_msgs[$];
    int        error_count = 0;
    int        items_used = 0;
    int        cycle_count = 0;
    bit        no_idle = 1'b0;

    midi_stream_message_splitter_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_midi_byte   (s_midi_byte),
        .s_buffer_last (s_buffer_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_msg_kind    (m_msg_kind),
        .m_byte0       (m_byte0),
        .m_byte1       (m_byte1),
        .m_byte2       (m_byte2),
        .m_msg_length  (m_msg_length),
        .m_sysex_end   (m_sysex_end),
        .m_run_end     (m_run_end)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("midi_stream_message_splitter_unit verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 13);
    end

    // Data bytes that follow a status byte; zero for statuses that stand alone.
    function automatic int data_bytes_for(input logic [7:0] st);
        int n;
        n = 0;
        if (st < SX_START) begin
            n = (st[7:4] == ST_PROG[7:4] || st[7:4] == ST_CHPRESS[7:4]) ? 1 : 2;
        end else if (st == SYS_MTC || st == SYS_SONGSEL) begin
            n = 1;
        end else if (st == SYS_SONGPOS) begin
            n = 2;
        end
        return n;
    endfunction

    function automatic void emit(input logic kind, input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2, input logic [1:0] len,
                                 input logic sx_end);
        midi_msg_t m;
        m.kind    = kind;
        m.b0      = b0;
        m.b1      = b1;
        m.b2      = b2;
        m.len     = len;
        m.sx_end  = sx_end;
        m.run_end = 1'b0;
        byte_msgs = {byte_msgs, m};
    endfunction

    function automatic void open_wait(input pend_class_t cls, input logic [7:0] st,
                                      input int need, input int cnt, input logic [7:0] first);
        wait_on     = 1'b1;
        wait_cls    = cls;
        wait_status = st;
        wait_need   = need[1:0];
        wait_count  = cnt[1:0];
        wait_first  = first;
    endfunction

    function automatic void close_wait();
        wait_on     = 1'b0;
        wait_cls    = CLS_CHANNEL;
        wait_status = 8'd0;
        wait_need   = 2'd0;
        wait_count  = 2'd0;
        wait_first  = 8'd0;
    endfunction

    function automatic logic [31:0] parser_state();
        return {run_status, sysex_on, wait_on, 2'(wait_cls), wait_status, wait_need,
                wait_count, wait_first};
    endfunction

    // A byte seen while no status is waiting for its data.
    function automatic void split_free_byte(input logic [7:0] b, input logic last);
        int need;
        need = data_bytes_for(b);
        if (b >= RT_FIRST) begin
            emit(KIND_SHORT, b, 8'd0, 8'd0, 2'd1, 1'b0);
        end else if (sysex_on) begin
            if (b == SX_END) sysex_on = 1'b0;
            emit(KIND_SYSEX, b, 8'd0, 8'd0, 2'd1, b == SX_END);
        end else if (b == SX_START) begin
            sysex_on   = 1'b1;
            run_status = 8'd0;
            emit(KIND_SYSEX, b, 8'd0, 8'd0, 2'd1, 1'b0);
        end else if (b[7]) begin
            if (b >= SX_START) begin
                run_status = 8'd0;
                if (need > 0 && !last) begin
                    open_wait(CLS_SYSTEM, b, need, 0, 8'd0);
                end else begin
                    emit(KIND_SHORT, b, 8'd0, 8'd0, 2'd1, 1'b0);
                end
            end else if (!last) begin
                open_wait(CLS_CHANNEL, b, need, 0, 8'd0);
            end
        end else if (run_status != 8'd0) begin
            if (data_bytes_for(run_status) == 1) begin
                emit(KIND_SHORT, run_status, b, 8'd0, 2'd2, 1'b0);
            end else if (!last) begin
                open_wait(CLS_CHANNEL, run_status, 2, 1, b);
            end
        end
    endfunction

    // A byte that falls into a data slot of a waiting status.
    function automatic void split_slot_byte(input logic [7:0] b, input logic last);
        logic [7:0]  st;
        pend_class_t cls;
        st  = wait_status;
        cls = wait_cls;
        if (wait_need == 2'd2 && wait_count == 2'd0) begin
            if (last) begin
                close_wait();
                // A system status cut short goes out alone and the byte is parsed again.
                if (cls == CLS_SYSTEM) begin
                    emit(KIND_SHORT, st, 8'd0, 8'd0, 2'd1, 1'b0);
                    split_free_byte(b, last);
                end
            end else begin
                wait_first = b;
                wait_count = 2'd1;
            end
        end else begin
            if (wait_need == 2'd1) begin
                emit(KIND_SHORT, st, b, 8'd0, 2'd2, 1'b0);
            end else begin
                emit(KIND_SHORT, st, wait_first, b, 2'd3, 1'b0);
            end
            if (cls == CLS_CHANNEL) run_status = st;
            close_wait();
        end
    endfunction

    function automatic bit split_byte(input logic [7:0] b, input logic last);
        logic [31:0] prior;
        prior = parser_state();
        byte_msgs.delete();
        if (wait_on) begin
            split_slot_byte(b, last);
        end else begin
            split_free_byte(b, last);
        end
        if (byte_msgs.size() > 0) byte_msgs[byte_msgs.size() - 1].run_end = 1'b1;
        foreach (byte_msgs[i]) msgs_due = {msgs_due, byte_msgs[i]};
        return (byte_msgs.size() > 0) || (parser_state() != prior);
    endfunction

    function automatic bit rand_last();
        return $urandom_range(99) < 12;
    endfunction

    task automatic feed_byte(input logic [7:0] b, input logic last);
        while (!no_idle && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_midi_byte   <= b;
        s_buffer_last <= last;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (split_byte(b, last)) items_used++;
    endtask

    task automatic send_data_group(input int count);
        repeat (count) feed_byte(8'($urandom_range(127)), rand_last());
    endtask

    task automatic compare_field(input string name, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        if (got_v !== want_v) begin
            error_count++;
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin : result_check
        midi_msg_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (msgs_due.size() == 0) begin
                error_count++;
                $error("byte0: expected no result, got %0h", m_byte0);
            end else begin
                want = msgs_due.pop_front();
                compare_field("msg_kind", 8'(want.kind), 8'(m_msg_kind));
                compare_field("byte0", want.b0, m_byte0);
                compare_field("byte1", want.b1, m_byte1);
                compare_field("byte2", want.b2, m_byte2);
                compare_field("msg_length", 8'(want.len), 8'(m_msg_length));
                compare_field("sysex_end", 8'(want.sx_end), 8'(m_sysex_end));
                compare_field("run_end", 8'(want.run_end), 8'(m_run_end));
            end
        end
    end

    task automatic test_channel_messages();
        feed_byte(8'h00, 1'b0);     // stray data with no running status
        feed_byte(8'h90, 1'b0);
        feed_byte(8'h3C, 1'b0);
        feed_byte(8'h7F, 1'b0);
        feed_byte(8'h40, 1'b0);     // running status note
        feed_byte(8'h00, 1'b0);
        feed_byte(8'hCF, 1'b0);
        feed_byte(8'h10, 1'b0);
        feed_byte(8'h11, 1'b1);     // one-byte running status completes at buffer end
    endtask

    task automatic test_buffer_edges();
        feed_byte(8'hEF, 1'b1);
        feed_byte(8'hE0, 1'b0);
        feed_byte(8'h01, 1'b1);
        feed_byte(8'hE0, 1'b0);
        feed_byte(8'h01, 1'b0);
        feed_byte(8'h02, 1'b0);
        feed_byte(8'h03, 1'b1);     // dropped under a two-byte running status
    endtask

    task automatic test_system_common();
        // Song position cut by the buffer end: status alone, then the real-time byte.
        feed_byte(SYS_SONGPOS, 1'b0);
        feed_byte(8'hF8, 1'b1);
        feed_byte(SYS_MTC, 1'b1);
        feed_byte(SYS_SONGSEL, 1'b0);
        feed_byte(8'hFF, 1'b0);     // data slot takes any byte
        feed_byte(8'hF4, 1'b0);
        feed_byte(8'hF5, 1'b0);
        feed_byte(8'hF6, 1'b0);
        feed_byte(SX_END, 1'b0);
    endtask

    task automatic test_sysex();
        feed_byte(SX_START, 1'b0);
        feed_byte(8'h7F, 1'b0);
        feed_byte(8'h90, 1'b1);
        feed_byte(8'hFE, 1'b0);
        feed_byte(SX_START, 1'b0);
        feed_byte(SX_END, 1'b1);
    endtask

    task automatic test_random_traffic();
        int         start_count;
        int         pick;
        logic [7:0] st;
        start_count = items_used;
        while (items_used - start_count < RANDOM_ITEMS) begin
            // One long stretch with both sides always ready.
            no_idle = (items_used - start_count >= 400) && (items_used - start_count < 650);
            pick = $urandom_range(99);
            if (pick < 30) begin
                st = 8'($urandom_range(8'hEF, 8'h80));
                feed_byte(st, rand_last());
                send_data_group(data_bytes_for(st));
                repeat ($urandom_range(3)) send_data_group(data_bytes_for(st));
            end else if (pick < 42) begin
                send_data_group($urandom_range(2, 1));
            end else if (pick < 52) begin
                feed_byte(8'($urandom_range(8'hFF, 8'hF8)), rand_last());
            end else if (pick < 68) begin
                feed_byte(SX_START, rand_last());
                repeat ($urandom_range(8)) begin
                    if ($urandom_range(9) == 0) begin
                        feed_byte(8'($urandom_range(8'hFF, 8'hF8)), rand_last());
                    end else begin
                        send_data_group(1);
                    end
                end
                feed_byte(SX_END, rand_last());
            end else if (pick < 82) begin
                st = 8'($urandom_range(8'hF6, 8'hF1));
                feed_byte(st, rand_last());
                send_data_group(data_bytes_for(st));
            end else begin
                feed_byte(8'($urandom_range(255)), rand_last());
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_channel_messages();
        test_buffer_edges();
        test_system_common();
        test_sysex();
        test_random_traffic();
        s_valid <= 1'b0;
        while (msgs_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("midi_stream_message_splitter_unit verification clean");
        end else begin
            $display("midi_stream_message_splitter_unit verification failed");
        end
        $finish;
    end

endmodule
